// File: src/lrpg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ring pattern generator.
// No dependencies; every other file in src imports this package.
package lrpg_pkg;

	// Payload types
	typedef logic [31:0] time_ms_t;
	typedef logic [7:0]  duty_t;

	// Number of ring positions (R,G,B,R,G,B)
	localparam int NUM_POS = 6;

	// Default effect periods in milliseconds
	localparam int LRPG_BREATH_PERIOD_DEF = 4000;
	localparam int LRPG_CHASE_PERIOD_DEF  = 1200;

	// Effect select codes; code 7 falls into the off arm as well
	typedef enum logic [2:0] {
		MODE_WARM    = 3'd0,
		MODE_COOL    = 3'd1,
		MODE_SOLID_R = 3'd2,
		MODE_SOLID_B = 3'd3,
		MODE_BREATH  = 3'd4,
		MODE_CHASE   = 3'd5,
		MODE_OFF     = 3'd6
	} lrpg_mode_t;

	// Fixed colors, red/green/blue
	localparam duty_t WARM_R = 8'd255;
	localparam duty_t WARM_G = 8'd150;
	localparam duty_t WARM_B = 8'd40;
	localparam duty_t COOL_R = 8'd150;
	localparam duty_t COOL_G = 8'd200;
	localparam duty_t COOL_B = 8'd255;
	localparam duty_t DUTY_FULL = 8'd255;
	localparam duty_t DUTY_ZERO = 8'd0;

endpackage

// File: src/lrpg_in_if.sv
`timescale 1ns / 1ps
// Timestamp channel: valid/ready handshake carrying one millisecond stamp.
// Depends on lrpg_pkg.
interface lrpg_in_if import lrpg_pkg::*; ();
	logic     valid;
	logic     ready;
	time_ms_t time_ms;

	modport source (output valid, output time_ms, input ready);
	modport sink   (input valid, input time_ms, output ready);
endinterface

// File: src/lrpg_out_if.sv
`timescale 1ns / 1ps
// Duty channel: valid/ready handshake carrying six PWM duties.
// Depends on lrpg_pkg.
interface lrpg_out_if import lrpg_pkg::*; ();
	logic  valid;
	logic  ready;
	duty_t duty_pos0;
	duty_t duty_pos1;
	duty_t duty_pos2;
	duty_t duty_pos3;
	duty_t duty_pos4;
	duty_t duty_pos5;

	modport source (output valid, input ready,
		output duty_pos0, output duty_pos1, output duty_pos2,
		output duty_pos3, output duty_pos4, output duty_pos5);
	modport sink (input valid, output ready,
		input duty_pos0, input duty_pos1, input duty_pos2,
		input duty_pos3, input duty_pos4, input duty_pos5);
endinterface

// File: src/led_ring_pattern_generator.sv
`timescale 1ns / 1ps
// Ring pattern generator top level: six-stage pipeline from timestamp to duties.
// Depends on lrpg_pkg, lrpg_in_if, lrpg_out_if and lrpg_breath_rom.
//
// Each timestamp transfer on the stamp channel yields exactly one transfer of
// six PWM duties on the duty channel. While the duty channel keeps up,
// a new stamp is taken every cycle; each stage holds its item and valid bit
// and moves only when the stage after it is free, so backpressure on the duty
// channel fills the pipe before stamp.ready drops. Stages: 1) multiply by the
// reciprocals of both periods, 2) quotient times period, 3) remainder with one
// correction step, 4) breathing ROM read and chase distance per position,
// 5) chase scaling multiply, 6) effect select into the output register. The
// breathing ROM has one entry per millisecond of its period and is constant,
// so no fill or clearing pass follows reset. The mode register is written
// through mode_we/mode_wdata and should change only while the pipe is empty.
module led_ring_pattern_generator import lrpg_pkg::*; #(
	parameter int BREATH_PERIOD_MS = LRPG_BREATH_PERIOD_DEF,
	parameter int CHASE_PERIOD_MS  = LRPG_CHASE_PERIOD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lrpg_in_if.sink           stamp,
	lrpg_out_if.source        duty,
	input  logic              mode_we,
	input  logic [2:0]        mode_wdata
);

	// Breathing period reduction
	localparam int BW = $clog2(BREATH_PERIOD_MS);
	localparam logic [31:0] B_RECIP = 32'((64'd1 << 32) / 64'(BREATH_PERIOD_MS));
	localparam logic [31:0] B_PER   = 32'(BREATH_PERIOD_MS);

	// Chase period reduction
	localparam int CW = $clog2(CHASE_PERIOD_MS);
	localparam logic [31:0] C_RECIP = 32'((64'd1 << 32) / 64'(CHASE_PERIOD_MS));
	localparam logic [31:0] C_PER   = 32'(CHASE_PERIOD_MS);

	// Chase distance arithmetic: e ranges up to 6*C
	localparam int EW = $clog2(6 * CHASE_PERIOD_MS + 1);
	localparam logic [EW-1:0] C_E  = EW'(CHASE_PERIOD_MS);
	localparam logic [EW-1:0] C3_E = EW'(3 * CHASE_PERIOD_MS);
	localparam logic [EW-1:0] C6_E = EW'(6 * CHASE_PERIOD_MS);

	// Exact floor(x / C) for x < 2^XW by one multiply and shift
	localparam int XW  = $clog2(255 * CHASE_PERIOD_MS + 1);
	localparam int SH  = XW + CW;
	localparam int MW  = XW + 1;
	localparam int PW  = XW + MW;
	localparam logic [MW-1:0] X_RECIP =
		MW'(((64'd1 << SH) + 64'(CHASE_PERIOD_MS) - 64'd1) / 64'(CHASE_PERIOD_MS));

	logic [2:0] mode_q;

	// Stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	// Stage payloads
	time_ms_t        t_s1, t_s2;
	logic [63:0]     bprod_s1, cprod_s1;
	logic [31:0]     bqp_s2, cqp_s2;
	logic [BW-1:0]   brem_s3;
	logic [CW-1:0]   crem_s3;
	duty_t           blvl_s4, blvl_s5;
	logic [XW-1:0]   x_s4 [NUM_POS];
	logic [PW-1:0]   xprod_s5 [NUM_POS];
	duty_t           duty_s6 [NUM_POS];

	// Combinational helpers
	logic [31:0]     bdiff, cdiff;
	logic [XW-1:0]   x_d [NUM_POS];
	duty_t           duty_d [NUM_POS];

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WARM;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// A stage loads when it is empty or its content moves on
	assign en6 = !v_s6 || duty.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign stamp.ready = en1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= stamp.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: timestamp times period reciprocals
	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1     <= stamp.time_ms;
			bprod_s1 <= 64'(stamp.time_ms) * 64'(B_RECIP);
			cprod_s1 <= 64'(stamp.time_ms) * 64'(C_RECIP);
		end
	end

	// Stage 2: quotient estimate (exact or one short) times period
	always_ff @(posedge clk) begin
		if (en2) begin
			t_s2   <= t_s1;
			bqp_s2 <= 32'(bprod_s1[63:32] * B_PER);
			cqp_s2 <= 32'(cprod_s1[63:32] * C_PER);
		end
	end

	// Stage 3: remainder below twice the period, one correction
	assign bdiff = t_s2 - bqp_s2;
	assign cdiff = t_s2 - cqp_s2;

	always_ff @(posedge clk) begin
		if (en3) begin
			brem_s3 <= (bdiff >= B_PER) ? BW'(bdiff - B_PER) : BW'(bdiff);
			crem_s3 <= (cdiff >= C_PER) ? CW'(cdiff - C_PER) : CW'(cdiff);
		end
	end

	// Stage 4: breathing level from ROM
	lrpg_breath_rom #(
		.PERIOD_MS (BREATH_PERIOD_MS)
	) u_breath_rom (
		.clk  (clk),
		.en   (en4),
		.addr (brem_s3),
		.data (blvl_s4)
	);

	// Stage 4: chase distance per position, scaled by 255
	always_comb begin
		logic [EW-1:0] q6;
		logic [EW-1:0] ci;
		logic [EW-1:0] e_abs;
		logic [EW-1:0] e_w;
		logic [XW-1:0] d;
		q6 = (EW'(crem_s3) << 2) + (EW'(crem_s3) << 1);
		for (int i = 0; i < NUM_POS; i++) begin
			ci    = EW'(CHASE_PERIOD_MS * i);
			e_abs = (ci >= q6) ? ci - q6 : q6 - ci;
			e_w   = (e_abs > C3_E) ? C6_E - e_abs : e_abs;
			d     = XW'(C_E - e_w);
			x_d[i] = (e_w >= C_E) ? '0 : (d << 8) - d;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			x_s4 <= x_d;
		end
	end

	// Stage 5: multiply by reciprocal of the chase period
	always_ff @(posedge clk) begin
		if (en5) begin
			blvl_s5 <= blvl_s4;
			for (int i = 0; i < NUM_POS; i++) begin
				xprod_s5[i] <= PW'(x_s4[i]) * PW'(X_RECIP);
			end
		end
	end

	// Stage 6: effect select
	always_comb begin
		for (int i = 0; i < NUM_POS; i++) begin
			unique case (mode_q)
				MODE_WARM:    duty_d[i] = (i % 3 == 0) ? WARM_R :
					(i % 3 == 1) ? WARM_G : WARM_B;
				MODE_COOL:    duty_d[i] = (i % 3 == 0) ? COOL_R :
					(i % 3 == 1) ? COOL_G : COOL_B;
				MODE_SOLID_R: duty_d[i] = (i % 3 == 0) ? DUTY_FULL : DUTY_ZERO;
				MODE_SOLID_B: duty_d[i] = (i % 3 == 2) ? DUTY_FULL : DUTY_ZERO;
				MODE_BREATH:  duty_d[i] = blvl_s5;
				MODE_CHASE:   duty_d[i] = 8'(xprod_s5[i] >> SH);
				default:      duty_d[i] = DUTY_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			duty_s6 <= duty_d;
		end
	end

	// Output channel
	assign duty.valid     = v_s6;
	assign duty.duty_pos0 = duty_s6[0];
	assign duty.duty_pos1 = duty_s6[1];
	assign duty.duty_pos2 = duty_s6[2];
	assign duty.duty_pos3 = duty_s6[3];
	assign duty.duty_pos4 = duty_s6[4];
	assign duty.duty_pos5 = duty_s6[5];

	// Remainders are fully reduced after the correction step
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (32'(brem_s3) < B_PER) && (32'(crem_s3) < C_PER))
		else $error("period remainder out of range");

	// The chase blob never lights more than two positions
	a_chase_width: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> $countones({x_s4[0] != '0, x_s4[1] != '0, x_s4[2] != '0,
			x_s4[3] != '0, x_s4[4] != '0, x_s4[5] != '0}) <= 2)
		else $error("chase lit more than two positions");

	// Off codes load all-zero duties
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(en6 && v_s5 && mode_q >= MODE_OFF) |=>
		(duty_s6[0] == DUTY_ZERO && duty_s6[1] == DUTY_ZERO && duty_s6[2] == DUTY_ZERO &&
		 duty_s6[3] == DUTY_ZERO && duty_s6[4] == DUTY_ZERO && duty_s6[5] == DUTY_ZERO))
		else $error("off mode produced a nonzero duty");

endmodule

// File: src/lrpg_breath_rom.sv
`timescale 1ns / 1ps
// Breathing level ROM: one 8-bit level per millisecond of the period,
// contents built at elaboration from a folded quarter sine. Uses lrpg_pkg.
module lrpg_breath_rom import lrpg_pkg::*; #(
	parameter int PERIOD_MS = LRPG_BREATH_PERIOD_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [$clog2(PERIOD_MS)-1:0] addr,
	output duty_t                        data
);

	localparam real HALF_PI = 1.5707963267948966;

	duty_t lut [PERIOD_MS];
	duty_t data_q;

	// Fold 4*p into the first quadrant, then floor((1 +- sin) * 127.5)
	for (genvar g = 0; g < PERIOD_MS; g++) begin : g_lut
		localparam int  A4  = 4 * g;
		localparam bit  NEG = (A4 >= 2 * PERIOD_MS);
		localparam int  AH  = NEG ? A4 - 2 * PERIOD_MS : A4;
		localparam int  AQ  = (AH > PERIOD_MS) ? 2 * PERIOD_MS - AH : AH;
		localparam real S   = (AQ == 0) ? 0.0 :
			(AQ >= PERIOD_MS) ? 1.0 : $sin(HALF_PI * AQ / PERIOD_MS);
		localparam real LV  = NEG ? (1.0 - S) * 127.5 : (1.0 + S) * 127.5;
		localparam int  LI  = $rtoi(LV);
		assign lut[g] = (LI > 255) ? DUTY_FULL : 8'(LI);
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= lut[addr];
		end
	end

	assign data = data_q;

endmodule

// File: bench/tb_led_ring_pattern_generator.sv
`timescale 1ns / 1ps
// Testbench for led_ring_pattern_generator: a directed table, then random stamps under
// each effect, checked against a bit-exact duty predictor. Depends on lrpg_pkg,
// lrpg_in_if, lrpg_out_if and the generator RTL.
module tb_led_ring_pattern_generator;
	import lrpg_pkg::*;

	// Code 7 has no name in the package; it must turn the ring off like MODE_OFF
	localparam logic [2:0] MODE_SPARE = 3'd7;

	localparam int BREATH_MS = LRPG_BREATH_PERIOD_DEF;
	localparam int CHASE_MS  = LRPG_CHASE_PERIOD_DEF;
	localparam logic [63:0] Q62_UNIT    = 64'h4000_0000_0000_0000;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

	localparam int PHASE_ITEMS = 70;
	localparam int HOLD_CYCLES = 200;
	localparam int MAX_REPORTS = 60;

	// Six duties, index 0 is ring position 0
	typedef duty_t [0:NUM_POS-1] ring_duty_t;

	typedef struct packed {
		logic [2:0] mode;
		time_ms_t   stamp;
		logic       typed;
		ring_duty_t want;
	} stim_row_t;

	// Directed rows; typed rows carry their duties, the rest use the predictor
	localparam int NUM_ROWS = 22;
	localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
		'{MODE_WARM,    32'h0000_0000, 1'b1, {8'd255, 8'd150, 8'd40, 8'd255, 8'd150, 8'd40}},
		'{MODE_WARM,    32'hFFFF_FFFF, 1'b1, {8'd255, 8'd150, 8'd40, 8'd255, 8'd150, 8'd40}},
		'{MODE_COOL,    32'h0000_0000, 1'b1, {8'd150, 8'd200, 8'd255, 8'd150, 8'd200, 8'd255}},
		'{MODE_SOLID_R, 32'd12345,     1'b1, {8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}},
		'{MODE_SOLID_B, 32'hFFFF_FFFF, 1'b1, {8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255}},
		'{MODE_BREATH,  32'd0,         1'b1, {6{8'd127}}},
		'{MODE_BREATH,  32'd1000,      1'b1, {6{8'd255}}},
		'{MODE_BREATH,  32'd2000,      1'b1, {6{8'd127}}},
		'{MODE_BREATH,  32'd3000,      1'b1, {6{8'd0}}},
		'{MODE_BREATH,  32'd4000,      1'b1, {6{8'd127}}},
		'{MODE_BREATH,  32'd1,         1'b0, 48'd0},
		'{MODE_BREATH,  32'd3999,      1'b0, 48'd0},
		'{MODE_BREATH,  32'hFFFF_FFFF, 1'b0, 48'd0},
		'{MODE_CHASE,   32'd0,         1'b1, {8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
		'{MODE_CHASE,   32'd200,       1'b1, {8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}},
		'{MODE_CHASE,   32'd100,       1'b1, {8'd127, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0}},
		'{MODE_CHASE,   32'd1000,      1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}},
		'{MODE_CHASE,   32'd1199,      1'b0, 48'd0},
		'{MODE_CHASE,   32'd1100,      1'b0, 48'd0},
		'{MODE_CHASE,   32'hFFFF_FFFF, 1'b0, 48'd0},
		'{MODE_OFF,     32'd0,         1'b1, 48'd0},
		'{MODE_SPARE,   32'hFFFF_FFFF, 1'b1, 48'd0}
	};

	// Effect per random phase; the idle profile cycles with the phase number
	localparam int NUM_PHASES = 12;
	localparam logic [2:0] PHASE_MODES [NUM_PHASES] = '{
		MODE_BREATH, MODE_CHASE, MODE_WARM, MODE_COOL, MODE_BREATH, MODE_SOLID_R,
		MODE_SOLID_B, MODE_CHASE, MODE_OFF, MODE_SPARE, MODE_BREATH, MODE_CHASE
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       mode_we;
	logic [2:0] mode_wdata;

	lrpg_in_if  stamp_if ();
	lrpg_out_if duty_if ();

	led_ring_pattern_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.stamp      (stamp_if),
		.duty       (duty_if),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata)
	);

	always #10 clk = ~clk;

	ring_duty_t duty_expect_q [$];
	logic [2:0] ring_mode = MODE_WARM;
	int         fault_cnt = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	logic       hold_req = 1'b0;
	logic       hold_taken = 1'b0;
	int         hold_left = 0;

	// (a * b) >> 62 on the full 128-bit product
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// sin(pi/2 * ang / per) in Q2.62 by Taylor series, 0 <= ang <= per
	function automatic logic [63:0] quarter_sine(input logic [63:0] ang,
			input logic [63:0] per);
		logic [63:0] x, x2, term, acc;
		if (ang == 64'd0)
			return 64'd0;
		if (ang >= per)
			return Q62_UNIT;
		x = (HALF_PI_Q62 / per) * ang + ((HALF_PI_Q62 % per) * ang) / per;
		x2 = q62_mul(x, x);
		term = x;
		acc = x;
		for (int k = 1; k <= 13; k++) begin
			term = q62_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
			if (k % 2)
				acc = acc - term;
			else
				acc = acc + term;
		end
		if (acc > Q62_UNIT)
			acc = Q62_UNIT;
		return acc;
	endfunction

	// Breathing level: fold 4*p into the first quadrant, then scale to 0..255
	function automatic duty_t breath_duty(input time_ms_t stamp);
		logic [63:0] per, ang, s, u, h, l, lvl;
		logic        neg;
		per = 64'(BREATH_MS);
		ang = 64'd4 * ({32'd0, stamp} % per);
		neg = 1'b0;
		if (ang >= 2 * per) begin
			neg = 1'b1;
			ang = ang - 2 * per;
		end
		if (ang > per)
			ang = 2 * per - ang;
		s = quarter_sine(ang, per);
		u = neg ? (Q62_UNIT - s) : (Q62_UNIT + s);
		h = u >> 55;
		l = u & ((64'd1 << 55) - 64'd1);
		lvl = (h * 64'd255 + ((l * 64'd255) >> 55)) >> 8;
		if (lvl > 64'd255)
			lvl = 64'd255;
		return lvl[7:0];
	endfunction

	// Chase level: triangular blob, distance scaled by six so it stays integer
	function automatic duty_t chase_duty(input time_ms_t stamp, input int pos);
		logic [63:0] c, q, ci, q6, e;
		c = 64'(CHASE_MS);
		q = {32'd0, stamp} % c;
		ci = c * 64'(pos);
		q6 = 64'd6 * q;
		e = (ci >= q6) ? ci - q6 : q6 - ci;
		if (e > 3 * c)
			e = 6 * c - e;
		if (e >= c)
			return 8'd0;
		return 8'(((c - e) * 64'd255) / c);
	endfunction

	function automatic ring_duty_t ring_duties_for(input logic [2:0] mode,
			input time_ms_t stamp);
		ring_duty_t r;
		duty_t      lvl;
		r = '0;
		case (mode)
			MODE_WARM:    r = {8'd255, 8'd150, 8'd40, 8'd255, 8'd150, 8'd40};
			MODE_COOL:    r = {8'd150, 8'd200, 8'd255, 8'd150, 8'd200, 8'd255};
			MODE_SOLID_R: r = {8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0};
			MODE_SOLID_B: r = {8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
			MODE_BREATH: begin
				lvl = breath_duty(stamp);
				r = {NUM_POS{lvl}};
			end
			MODE_CHASE: begin
				for (int i = 0; i < NUM_POS; i++)
					r[i] = chase_duty(stamp, i);
			end
			default:      r = '0;
		endcase
		return r;
	endfunction

	// Random stamps biased toward small values, the wrap and period boundaries
	function automatic time_ms_t next_stamp();
		time_ms_t s;
		case ($urandom_range(0, 9))
			0:       s = $urandom_range(0, 5000);
			1:       s = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			2:       s = $urandom_range(0, 21474836) * 200 + $urandom_range(0, 2) - 1;
			3:       s = $urandom_range(0, 4294967) * 1000 + $urandom_range(0, 2) - 1;
			default: s = $urandom();
		endcase
		return s;
	endfunction

	// One stamp transfer; random gaps in front of it, valid left high after
	task automatic send_stamp(input time_ms_t stamp, input logic typed,
			input ring_duty_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			stamp_if.valid <= 1'b0;
			stamp_if.time_ms <= $urandom();
			@(posedge clk);
		end
		stamp_if.valid <= 1'b1;
		stamp_if.time_ms <= stamp;
		@(posedge clk);
		while (!stamp_if.ready)
			@(posedge clk);
		duty_expect_q.push_back(typed ? want : ring_duties_for(ring_mode, stamp));
	endtask

	// Mode write once the pipe has handed back every result
	task automatic write_mode(input logic [2:0] m);
		stamp_if.valid <= 1'b0;
		while (duty_expect_q.size() != 0)
			@(posedge clk);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
		ring_mode = m;
	endtask

	// Duty sink: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			duty_if.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			duty_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			duty_if.ready <= 1'b0;
		end else begin
			duty_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compare each duty transfer against the oldest expectation
	always @(posedge clk) begin
		ring_duty_t got, want;
		if (arst_n && duty_if.valid && duty_if.ready) begin
			got = {duty_if.duty_pos0, duty_if.duty_pos1, duty_if.duty_pos2,
				duty_if.duty_pos3, duty_if.duty_pos4, duty_if.duty_pos5};
			if (duty_expect_q.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= MAX_REPORTS)
					$display("%0t unexpected duty transfer, expected none, actual %h",
						$time, got);
			end else begin
				want = duty_expect_q.pop_front();
				for (int i = 0; i < NUM_POS; i++) begin
					if (got[i] !== want[i]) begin
						fault_cnt++;
						if (fault_cnt <= MAX_REPORTS)
							$display("%0t duty_pos%0d expected %0d actual %0d",
								$time, i, want[i], got[i]);
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("[led_ring_pattern_generator] ERROR");
		$finish;
	end

	initial begin
		int rest;
		arst_n = 1'b0;
		mode_we = 1'b0;
		mode_wdata = MODE_WARM;
		stamp_if.valid = 1'b0;
		stamp_if.time_ms = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (STIM_ROWS[r].mode != ring_mode)
				write_mode(STIM_ROWS[r].mode);
			send_stamp(STIM_ROWS[r].stamp, STIM_ROWS[r].typed, STIM_ROWS[r].want);
		end

		// Random phases, one effect and one idle profile each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_mode(PHASE_MODES[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 79; end
				default: begin send_idle_pct = 12; recv_stall_pct <= 12; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long sink hold-off while stamps keep coming, so the pipe backs up
				if (ph == 0 && n == 5)
					hold_req <= 1'b1;
				send_stamp(next_stamp(), 1'b0, '0);
			end
		end

		// Drain, then allow the pipeline depth for stray transfers
		stamp_if.valid <= 1'b0;
		for (int n = 0; n < 5000 && duty_expect_q.size() != 0; n++)
			@(posedge clk);
		rest = duty_expect_q.size();
		if (rest != 0) begin
			$display("%0t %0d duty transfers never arrived, expected 0 left, actual %0d",
				$time, rest, rest);
		end
		repeat (12) @(posedge clk);
		if (fault_cnt == 0 && rest == 0)
			$display("[led_ring_pattern_generator] OK");
		else
			$display("[led_ring_pattern_generator] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
src/lrpg_pkg.sv
src/lrpg_in_if.sv
src/lrpg_out_if.sv
src/lrpg_breath_rom.sv
src/led_ring_pattern_generator.sv
bench/tb_led_ring_pattern_generator.sv
